### hdl/yuyv_pkg.sv
// yuyv_pkg: constants, types and arithmetic helpers for the yuyv to rgb24 converter
// no dependencies; used by the top level and the checker

package yuyv_pkg;

	localparam int ProdW  = 18;
	localparam int TermW  = 10;
	localparam int ColorW = 12;

	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [TermW-1:0]  term_t;
	typedef logic signed [ColorW-1:0] color_t;
	typedef logic [7:0]               byte_t;

	localparam prod_t LUMA_GAIN   = 18'sd298;
	localparam prod_t RV_GAIN     = 18'sd409;
	localparam prod_t GU_GAIN     = 18'sd100;
	localparam prod_t GV_GAIN     = 18'sd208;
	localparam prod_t BU_GAIN     = 18'sd516;
	localparam prod_t LUMA_OFFSET = 18'sd16;
	localparam prod_t CHROMA_MID  = 18'sd128;
	localparam prod_t ROUND_BIAS  = 18'sd128;
	localparam color_t COLOR_MAX  = 12'sd255;

	typedef enum logic {
		ORDER_RGB = 1'b0,
		ORDER_BGR = 1'b1
	} order_t;

	// 298*(y-16)+128, fits 18 bits signed
	function automatic prod_t luma_prod(input byte_t y);
		prod_t d;
		d = prod_t'({10'b0, y}) - LUMA_OFFSET;
		return prod_t'(d * LUMA_GAIN) + ROUND_BIAS;
	endfunction

	// k*(c-128)+128, fits 18 bits signed for every k used here
	function automatic prod_t chroma_prod(input byte_t c, input prod_t k);
		prod_t d;
		d = prod_t'({10'b0, c}) - CHROMA_MID;
		return prod_t'(d * k) + ROUND_BIAS;
	endfunction

	// flooring shift by 8, result range -258..278
	function automatic term_t shift_term(input prod_t p);
		prod_t s;
		s = p >>> 8;
		return s[TermW-1:0];
	endfunction

	function automatic color_t widen(input term_t t);
		return color_t'(t);
	endfunction

	function automatic byte_t clamp_byte(input color_t v);
		byte_t r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > COLOR_MAX) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

### hdl/yuyv_to_rgb24_converter_top.sv
// yuyv_to_rgb24_converter_top: three-stage pipeline, one yuyv macropixel to two rgb24 pixels
// depends on yuyv_pkg
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ----------------------------------------------
// input     in         start && !busy         luma_first, chroma_blue, luma_second,
//                                             chroma_red, frame_end
// result    out        done (one cycle)       first_byte_a/b/c, second_byte_a/b/c, frame_last
// config    in         order_we               order_wdata (0: r,g,b  1: b,g,r)
//
// one macropixel may be started every clock; busy is held low
// each result passes through three registered stages: stage 1 holds the constant
// multiplies, stage 2 the flooring shift and color sums, stage 3 saturation and byte order
// the receiver cannot stall, so nothing in the pipeline ever waits
// arst_n clears the valid bits and the byte order register (rgb order)

module yuyv_to_rgb24_converter_top
	import yuyv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input transfer
	input  logic       start,
	output logic       busy,
	input  logic [7:0] luma_first,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] luma_second,
	input  logic [7:0] chroma_red,
	input  logic       frame_end,
	// configuration
	input  logic       order_we,
	input  logic       order_wdata,
	// result transfer
	output logic       done,
	output logic [7:0] first_byte_a,
	output logic [7:0] first_byte_b,
	output logic [7:0] first_byte_c,
	output logic [7:0] second_byte_a,
	output logic [7:0] second_byte_b,
	output logic [7:0] second_byte_c,
	output logic       frame_last
);

	// byte order register
	order_t order_q;

	// stage 1: products
	logic  vld_s1;
	logic  fe_s1;
	prod_t lp0_s1, lp1_s1, rv_s1, gu_s1, gv_s1, bu_s1;

	// stage 2: unsaturated colors
	logic   vld_s2;
	logic   fe_s2;
	color_t r0_s2, g0_s2, b0_s2, r1_s2, g1_s2, b1_s2;

	// stage 3: output bytes
	logic  vld_s3;
	logic  fe_s3;
	byte_t p0a_s3, p0b_s3, p0c_s3, p1a_s3, p1b_s3, p1c_s3;

	// stage 2 combinational terms
	color_t l0_w, l1_w, rv_w, gu_w, gv_w, bu_w;

	// stage 3 combinational saturation
	byte_t r0_w, g0_w, b0_w, r1_w, g1_w, b1_w;

	logic accept;

	// no back pressure anywhere, so the block is always ready
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RGB;
		end else if (order_we) begin
			order_q <= order_t'(order_wdata);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: one constant multiply per term
	always_ff @(posedge clk) begin
		if (accept) begin
			lp0_s1 <= luma_prod(luma_first);
			lp1_s1 <= luma_prod(luma_second);
			rv_s1  <= chroma_prod(chroma_red, RV_GAIN);
			gu_s1  <= chroma_prod(chroma_blue, GU_GAIN);
			gv_s1  <= chroma_prod(chroma_red, GV_GAIN);
			bu_s1  <= chroma_prod(chroma_blue, BU_GAIN);
			fe_s1  <= frame_end;
		end
	end

	// stage 2: flooring shift then sums, chroma terms shared by both pixels
	always_comb begin
		l0_w = widen(shift_term(lp0_s1));
		l1_w = widen(shift_term(lp1_s1));
		rv_w = widen(shift_term(rv_s1));
		gu_w = widen(shift_term(gu_s1));
		gv_w = widen(shift_term(gv_s1));
		bu_w = widen(shift_term(bu_s1));
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			r0_s2 <= l0_w + rv_w;
			g0_s2 <= l0_w - gu_w - gv_w;
			b0_s2 <= l0_w + bu_w;
			r1_s2 <= l1_w + rv_w;
			g1_s2 <= l1_w - gu_w - gv_w;
			b1_s2 <= l1_w + bu_w;
			fe_s2 <= fe_s1;
		end
	end

	// stage 3: saturate to 0..255 and apply byte order
	always_comb begin
		r0_w = clamp_byte(r0_s2);
		g0_w = clamp_byte(g0_s2);
		b0_w = clamp_byte(b0_s2);
		r1_w = clamp_byte(r1_s2);
		g1_w = clamp_byte(g1_s2);
		b1_w = clamp_byte(b1_s2);
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			p0b_s3 <= g0_w;
			p1b_s3 <= g1_w;
			fe_s3  <= fe_s2;
			unique case (order_q)
				ORDER_RGB: begin
					p0a_s3 <= r0_w;
					p0c_s3 <= b0_w;
					p1a_s3 <= r1_w;
					p1c_s3 <= b1_w;
				end
				ORDER_BGR: begin
					p0a_s3 <= b0_w;
					p0c_s3 <= r0_w;
					p1a_s3 <= b1_w;
					p1c_s3 <= r1_w;
				end
				default: begin
					p0a_s3 <= r0_w;
					p0c_s3 <= b0_w;
					p1a_s3 <= r1_w;
					p1c_s3 <= b1_w;
				end
			endcase
		end
	end

	assign done          = vld_s3;
	assign first_byte_a  = p0a_s3;
	assign first_byte_b  = p0b_s3;
	assign first_byte_c  = p0c_s3;
	assign second_byte_a = p1a_s3;
	assign second_byte_b = p1b_s3;
	assign second_byte_c = p1c_s3;
	assign frame_last    = fe_s3;

endmodule

### hdl/yuyv_checker.sv
// yuyv_checker: port-level assertions for the converter top level
// depends on yuyv_pkg; bound to yuyv_to_rgb24_converter_top

module yuyv_checker
	import yuyv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       frame_end,
	input logic       done,
	input logic       frame_last
);

	// every transfer yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("missing result three cycles after input transfer");

	// no result without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3) && !$past(busy, 3))
		else $error("result without a matching input transfer");

	// frame flag travels with its item
	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> frame_last == $past(frame_end, 3))
		else $error("frame flag does not match its input");

	// never stalls the source
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind yuyv_to_rgb24_converter_top yuyv_checker u_yuyv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.frame_end  (frame_end),
	.done       (done),
	.frame_last (frame_last)
);

### verif/yuyv_to_rgb24_converter_top_tb.sv
// testbench for yuyv_to_rgb24_converter_top: directed and random yuyv macropixels in both byte orders
// depends on yuyv_pkg and the converter rtl; results are checked against a local bt.601 integer model

module yuyv_to_rgb24_converter_top_tb;
	import yuyv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 8;     // pipeline is three deep, leave some margin
	localparam int GapPercent  = 29;
	localparam int MaxReports  = 10;
	localparam int PhaseItems  = 250;
	localparam int Phases      = 6;

	// one yuyv macropixel as it goes onto the input ports
	typedef struct packed {
		byte_t y0;
		byte_t u;
		byte_t y1;
		byte_t v;
		logic  fe;
	} macropixel_t;

	// one result: two pixels of three bytes plus the frame flag
	typedef struct packed {
		byte_t first_a;
		byte_t first_b;
		byte_t first_c;
		byte_t second_a;
		byte_t second_b;
		byte_t second_c;
		logic  last;
	} pixel_pair_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        start       = 1'b0;
	logic        busy;
	macropixel_t cur_px      = '0;
	logic        order_we    = 1'b0;
	logic        order_wdata = 1'b0;

	logic       done;
	logic [7:0] first_byte_a;
	logic [7:0] first_byte_b;
	logic [7:0] first_byte_c;
	logic [7:0] second_byte_a;
	logic [7:0] second_byte_b;
	logic [7:0] second_byte_c;
	logic       frame_last;

	macropixel_t pending_pixels[$];   // macropixels waiting for the driver
	pixel_pair_t expected_pairs[$];   // predicted results, oldest first
	order_t      order_copy = ORDER_RGB;  // mirror of the byte order register
	logic        no_gaps    = 1'b0;   // sender runs flat out while set

	int mismatches = 0;
	int cycles     = 0;

	yuyv_to_rgb24_converter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.luma_first    (cur_px.y0),
		.chroma_blue   (cur_px.u),
		.luma_second   (cur_px.y1),
		.chroma_red    (cur_px.v),
		.frame_end     (cur_px.fe),
		.order_we      (order_we),
		.order_wdata   (order_wdata),
		.done          (done),
		.first_byte_a  (first_byte_a),
		.first_byte_b  (first_byte_b),
		.first_byte_c  (first_byte_c),
		.second_byte_a (second_byte_a),
		.second_byte_b (second_byte_b),
		.second_byte_c (second_byte_c),
		.frame_last    (frame_last)
	);

	// ---------------------------------------------------------------- prediction

	// (k*(c-128)+128) >> 8 with a flooring shift
	function automatic int chroma_term(int k, byte_t c);
		return (k * (int'(c) - 128) + 128) >>> 8;
	endfunction

	function automatic byte_t saturate(int x);
		if (x < 0) begin
			return 8'd0;
		end else if (x > 255) begin
			return 8'd255;
		end
		return byte_t'(x);
	endfunction

	// three output bytes of one pixel in the selected order
	function automatic logic [23:0] pixel_bytes(byte_t y, int rv, int gu, int gv, int bu,
			order_t ord);
		int    luma;
		byte_t r, g, b;
		luma = (298 * (int'(y) - 16) + 128) >>> 8;
		r = saturate(luma + rv);
		g = saturate(luma - gu - gv);
		b = saturate(luma + bu);
		return (ord == ORDER_BGR) ? {b, g, r} : {r, g, b};
	endfunction

	function automatic pixel_pair_t predict_pair(macropixel_t px, order_t ord);
		int          rv, gu, gv, bu;
		pixel_pair_t res;
		rv = chroma_term(409, px.v);
		gu = chroma_term(100, px.u);
		gv = chroma_term(208, px.v);
		bu = chroma_term(516, px.u);
		{res.first_a, res.first_b, res.first_c}    = pixel_bytes(px.y0, rv, gu, gv, bu, ord);
		{res.second_a, res.second_b, res.second_c} = pixel_bytes(px.y1, rv, gu, gv, bu, ord);
		res.last = px.fe;
		return res;
	endfunction

	// ---------------------------------------------------------------- clock and cycle limit

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs or drops results
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driver

	// a transfer happens at an edge with start high and busy low; the prediction is made
	// right there with the byte order in force; a held item stays on the ports while busy
	always @(posedge clk) begin : drive_blk
		macropixel_t px;
		if (arst_n) begin
			if (start && !busy) begin
				expected_pairs.push_back(predict_pair(cur_px, order_copy));
			end
			if (!(start && busy)) begin
				if (pending_pixels.size() != 0 &&
						(no_gaps || $urandom_range(99) >= GapPercent)) begin
					px = pending_pixels.pop_front();
					cur_px <= px;
					start  <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// the strobe lasts one cycle and the receiver cannot stall, so sample every edge
	always @(posedge clk) begin : check_blk
		pixel_pair_t got, want;
		if (arst_n && done) begin
			got = '{first_byte_a, first_byte_b, first_byte_c,
				second_byte_a, second_byte_b, second_byte_c, frame_last};
			if (expected_pairs.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MaxReports) begin
					$display("unexpected result at cycle %0d: %h %h %h / %h %h %h last %b",
						cycles, got.first_a, got.first_b, got.first_c,
						got.second_a, got.second_b, got.second_c, got.last);
				end
			end else begin
				want = expected_pairs.pop_front();
				if (got.first_a !== want.first_a || got.first_b !== want.first_b ||
						got.first_c !== want.first_c || got.second_a !== want.second_a ||
						got.second_b !== want.second_b || got.second_c !== want.second_c ||
						got.last !== want.last) begin
					mismatches <= mismatches + 1;
					if (mismatches < MaxReports) begin
						$display("mismatch at cycle %0d", cycles);
						$display("  expected %h %h %h / %h %h %h last %b",
							want.first_a, want.first_b, want.first_c,
							want.second_a, want.second_b, want.second_c, want.last);
						$display("  actual   %h %h %h / %h %h %h last %b",
							got.first_a, got.first_b, got.first_c,
							got.second_a, got.second_b, got.second_c, got.last);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_pixel(byte_t y0, byte_t u, byte_t y1, byte_t v, logic fe);
		macropixel_t px;
		px = '{y0, u, y1, v, fe};
		pending_pixels.push_back(px);
	endtask

	// sender holds off until the pipe is empty and every result is back
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || start || expected_pairs.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// register write only ever happens while the block is idle
	task automatic write_order(order_t ord);
		@(posedge clk);
		order_we    <= 1'b1;
		order_wdata <= ord;
		@(posedge clk);
		order_we   <= 1'b0;
		order_copy = ord;
		@(negedge clk);
	endtask

	// corners: black, white, nominal range, luma below 16, chroma extremes and mixes
	task automatic queue_directed();
		queue_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		queue_pixel(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
		queue_pixel(8'd0,   8'd128, 8'd15,  8'd128, 1'b0);
		queue_pixel(8'd128, 8'd0,   8'd128, 8'd0,   1'b0);
		queue_pixel(8'd128, 8'd255, 8'd128, 8'd255, 1'b0);
		queue_pixel(8'd128, 8'd0,   8'd128, 8'd255, 1'b0);
		queue_pixel(8'd128, 8'd255, 8'd128, 8'd0,   1'b1);
		queue_pixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
		queue_pixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
		queue_pixel(8'd17,  8'd127, 8'd16,  8'd129, 1'b0);
		queue_pixel(8'd240, 8'd128, 8'd1,   8'd128, 1'b1);
	endtask

	// mostly uniform samples, with some bias toward the saturating corners
	function automatic byte_t pick_sample(int mode);
		case (mode)
			0: begin
				return byte_t'($urandom_range(20));
			end
			1: begin
				return byte_t'($urandom_range(255, 230));
			end
			default: begin
				return byte_t'($urandom);
			end
		endcase
	endfunction

	task automatic queue_random(int count);
		int lmode, cmode;
		for (int i = 0; i < count; i++) begin
			lmode = ($urandom_range(9) < 7) ? 2 : int'($urandom_range(1));
			cmode = ($urandom_range(9) < 7) ? 2 : int'($urandom_range(1));
			queue_pixel(pick_sample(lmode), pick_sample(cmode), pick_sample(lmode),
				pick_sample(cmode), ($urandom_range(15) == 0));
		end
	endtask

	initial begin
		// single reset at the start of the run
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners, first with the reset byte order then with bgr
		queue_directed();
		wait_idle();
		write_order(ORDER_BGR);
		queue_directed();
		wait_idle();

		// random phases; the order alternates and is rewritten with its own value once,
		// phase two runs with no gaps at all
		for (int p = 0; p < Phases; p++) begin
			write_order((((p % 2) == 1) != (p >= 3)) ? ORDER_BGR : ORDER_RGB);
			no_gaps = (p == 2);
			queue_random(PhaseItems);
			wait_idle();
		end
		no_gaps = 1'b0;

		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
